FILE: rtl/core/battery_voltage_display_filter_unit_assert.svh
// Assertion macros for the battery voltage display filter.
// Used by the top level; depends on nothing else.
`ifndef BATTERY_VOLTAGE_DISPLAY_FILTER_UNIT_ASSERT_SVH
`define BATTERY_VOLTAGE_DISPLAY_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bvdf_pkg.sv
// Package for the battery voltage display filter: constants and register indexes.
// Depends on nothing; used by the top level.
package bvdf_pkg;

    localparam int unsigned AVG_W   = 28;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned PROD_W  = AVG_W + COEF_W;
    localparam int unsigned VALUE_W = 10;

    localparam logic [COEF_W-1:0] KEEP_Q16      = 16'd64881;
    localparam logic [COEF_W-1:0] ALPHA_Q16     = 16'd655;
    localparam logic [COEF_W-1:0] SCALE_HUNDRED = 16'd100;
    localparam logic [COEF_W-1:0] RECIP_DIV100  = 16'd41;
    localparam logic [COEF_W-1:0] RECIP_DIV10   = 16'd205;
    localparam logic [PROD_W-1:0] ROUND_HALF    = 44'd32768;

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 10'd999;
    localparam logic [15:0]        MAX_MS    = 16'hFFFF;

    localparam logic signed [15:0] FAST_THR_RESET  = 16'sd500;
    localparam logic signed [15:0] SLOW_THR_RESET  = 16'sd50;
    localparam logic [9:0]         LARGE_STEP_RESET = 10'd10;
    localparam logic [9:0]         SMALL_STEP_RESET = 10'd2;
    localparam logic [15:0]        HOLD_MS_RESET    = 16'd1500;

    typedef enum logic [2:0] {
        CFG_FAST_THR   = 3'd0,
        CFG_SLOW_THR   = 3'd1,
        CFG_LARGE_STEP = 3'd2,
        CFG_SMALL_STEP = 3'd3,
        CFG_HOLD_MS    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        LEVEL_NONE = 2'd0,
        LEVEL_SLOW = 2'd1,
        LEVEL_FAST = 2'd2
    } charge_level_t;

endpackage

FILE: rtl/core/battery_voltage_display_filter_unit.sv
// Battery voltage display filter: average, hysteresis and digit split of battery samples.
// Depends on bvdf_pkg and battery_voltage_display_filter_unit_assert.svh.
// States: IDLE, KEEP, ALPHA, SCALE, DECIDE, DIV100, DIV10; the seeding item skips KEEP and ALPHA.
// One shared 28x16 multiplier is used in five steps, so items are taken one at a time.
// in_stall is high from acceptance until the result is written to the output register.
// Reset (rst_n low, asynchronous) restores default configuration and clears all filter state.
module battery_voltage_display_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] voltage_sample,
    input  logic signed [15:0] charge_current,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  charge_level,
    output logic [9:0]  shown_hundredths,
    output logic [3:0]  digit_volts,
    output logic [3:0]  digit_tenths,
    output logic [3:0]  digit_hundredths,
    output logic [9:0]  filtered_hundredths,
    output logic        shown_updated
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEEP,
        ST_ALPHA,
        ST_SCALE,
        ST_DECIDE,
        ST_DIV100,
        ST_DIV10
    } state_t;

    state_t state_reg;

    logic signed [15:0] fast_thr_reg;
    logic signed [15:0] slow_thr_reg;
    logic [9:0]         large_step_reg;
    logic [9:0]         small_step_reg;
    logic [15:0]        hold_ms_reg;

    logic [bvdf_pkg::AVG_W-1:0]  avg_reg;
    logic                        seeded_reg;
    logic [9:0]                  shown_reg;
    logic                        shown_valid_reg;
    logic [15:0]                 since_reg;

    logic [15:0]                 vin_reg;
    logic [1:0]                  level_reg;
    logic [bvdf_pkg::PROD_W-1:0] prod_reg;
    logic [9:0]                  filt_reg;
    logic                        upd_reg;
    logic [3:0]                  hund_reg;
    logic [6:0]                  rem_reg;

    logic                        out_valid_reg;
    logic [1:0]                  level_out_reg;
    logic [9:0]                  shown_out_reg;
    logic [3:0]                  volts_out_reg;
    logic [3:0]                  tenths_out_reg;
    logic [3:0]                  hundredths_out_reg;
    logic [9:0]                  filt_out_reg;
    logic                        upd_out_reg;

    logic [bvdf_pkg::AVG_W-1:0]  mul_a;
    logic [bvdf_pkg::COEF_W-1:0] mul_b;
    logic [bvdf_pkg::PROD_W-1:0] mul_p;

    logic                        in_accept;
    logic                        out_free;
    logic [1:0]                  level_next;
    logic [16:0]                 since_sum;
    logic [15:0]                 since_next;
    logic [bvdf_pkg::PROD_W-1:0] acc_next;
    logic [10:0]                 filt_wide;
    logic [9:0]                  filt_next;
    logic [9:0]                  diff;
    logic                        upd_next;
    logic [3:0]                  hund_next;
    logic [9:0]                  hund_x100;
    logic [6:0]                  rem_next;
    logic [3:0]                  tens_next;
    logic [6:0]                  tens_x10;
    logic [3:0]                  ones_next;

    // The shared multiplier takes its operands from the step in progress.
    always_comb
    begin
        case (state_reg)
            ST_KEEP:
            begin
                mul_a = avg_reg;
                mul_b = bvdf_pkg::KEEP_Q16;
            end
            ST_ALPHA:
            begin
                mul_a = {12'd0, vin_reg};
                mul_b = bvdf_pkg::ALPHA_Q16;
            end
            ST_SCALE:
            begin
                mul_a = avg_reg;
                mul_b = bvdf_pkg::SCALE_HUNDRED;
            end
            ST_DIV100:
            begin
                mul_a = {18'd0, shown_reg};
                mul_b = bvdf_pkg::RECIP_DIV100;
            end
            ST_DIV10:
            begin
                mul_a = {21'd0, rem_reg};
                mul_b = bvdf_pkg::RECIP_DIV10;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {16'd0, mul_a} * {28'd0, mul_b};

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (charge_current > fast_thr_reg)
        begin
            level_next = bvdf_pkg::LEVEL_FAST;
        end
        else if (charge_current > slow_thr_reg)
        begin
            level_next = bvdf_pkg::LEVEL_SLOW;
        end
        else
        begin
            level_next = bvdf_pkg::LEVEL_NONE;
        end
    end

    assign since_sum  = {1'b0, since_reg} + {1'b0, elapsed_ms};
    assign since_next = since_sum[16] ? bvdf_pkg::MAX_MS : since_sum[15:0];

    assign acc_next = prod_reg + {mul_p[31:0], 12'd0} + bvdf_pkg::ROUND_HALF;

    assign filt_wide = mul_p[34:24];
    assign filt_next = (filt_wide > {1'b0, bvdf_pkg::MAX_SHOWN}) ? bvdf_pkg::MAX_SHOWN
                                                                 : filt_wide[9:0];

    assign diff     = (filt_reg >= shown_reg) ? (filt_reg - shown_reg) : (shown_reg - filt_reg);
    assign upd_next = !shown_valid_reg || (diff > large_step_reg) ||
                      ((diff > small_step_reg) && (since_reg > hold_ms_reg));

    assign hund_next = mul_p[15:12];
    assign hund_x100 = ({6'd0, hund_next} << 6) + ({6'd0, hund_next} << 5) +
                       ({6'd0, hund_next} << 2);
    assign rem_next  = 7'(shown_reg - hund_x100);

    assign tens_next = mul_p[14:11];
    assign tens_x10  = ({3'd0, tens_next} << 3) + ({3'd0, tens_next} << 1);
    assign ones_next = 4'(rem_reg - tens_x10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fast_thr_reg    <= bvdf_pkg::FAST_THR_RESET;
            slow_thr_reg    <= bvdf_pkg::SLOW_THR_RESET;
            large_step_reg  <= bvdf_pkg::LARGE_STEP_RESET;
            small_step_reg  <= bvdf_pkg::SMALL_STEP_RESET;
            hold_ms_reg     <= bvdf_pkg::HOLD_MS_RESET;
            avg_reg         <= '0;
            seeded_reg      <= 1'b0;
            shown_reg       <= '0;
            shown_valid_reg <= 1'b0;
            since_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bvdf_pkg::CFG_FAST_THR:   fast_thr_reg   <= cfg_data;
                    bvdf_pkg::CFG_SLOW_THR:   slow_thr_reg   <= cfg_data;
                    bvdf_pkg::CFG_LARGE_STEP: large_step_reg <= cfg_data[9:0];
                    bvdf_pkg::CFG_SMALL_STEP: small_step_reg <= cfg_data[9:0];
                    bvdf_pkg::CFG_HOLD_MS:    hold_ms_reg    <= cfg_data;
                    default:                  ;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != ST_DIV10))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        vin_reg   <= voltage_sample;
                        level_reg <= level_next;
                        since_reg <= since_next;
                        if (!seeded_reg)
                        begin
                            avg_reg    <= {voltage_sample, 12'd0};
                            seeded_reg <= 1'b1;
                            state_reg  <= ST_SCALE;
                        end
                        else
                        begin
                            state_reg <= ST_KEEP;
                        end
                    end
                end
                ST_KEEP:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ALPHA;
                end
                ST_ALPHA:
                begin
                    avg_reg   <= acc_next[43:16];
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    filt_reg  <= filt_next;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    upd_reg <= upd_next;
                    if (upd_next)
                    begin
                        shown_reg       <= filt_reg;
                        shown_valid_reg <= 1'b1;
                        since_reg       <= '0;
                    end
                    state_reg <= ST_DIV100;
                end
                ST_DIV100:
                begin
                    hund_reg  <= hund_next;
                    rem_reg   <= rem_next;
                    state_reg <= ST_DIV10;
                end
                ST_DIV10:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        level_out_reg      <= level_reg;
                        shown_out_reg      <= shown_reg;
                        volts_out_reg      <= hund_reg;
                        tenths_out_reg     <= tens_next;
                        hundredths_out_reg <= ones_next;
                        filt_out_reg       <= filt_reg;
                        upd_out_reg        <= upd_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign charge_level        = level_out_reg;
    assign shown_hundredths    = shown_out_reg;
    assign digit_volts         = volts_out_reg;
    assign digit_tenths        = tenths_out_reg;
    assign digit_hundredths    = hundredths_out_reg;
    assign filtered_hundredths = filt_out_reg;
    assign shown_updated       = upd_out_reg;

`include "battery_voltage_display_filter_unit_assert.svh"

    `BVDF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall, "not busy after an accepted item")
    `BVDF_ASSERT_SAME(a_update_follows_filter, clk, rst_n, out_valid && shown_updated, shown_hundredths == filtered_hundredths, "updated shown value differs from filtered value")
    `BVDF_ASSERT_SAME(a_digits_match, clk, rst_n, out_valid, ({6'd0, digit_volts} * 10'd100 + {6'd0, digit_tenths} * 10'd10 + {6'd0, digit_hundredths}) == shown_hundredths, "digits do not match shown value")
    `BVDF_ASSERT_SAME(a_filter_saturated, clk, rst_n, out_valid, filtered_hundredths <= bvdf_pkg::MAX_SHOWN, "filtered value above saturation limit")

endmodule

FILE: tb/tb_battery_voltage_display_filter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for battery_voltage_display_filter_unit: drives battery samples
// and register writes, predicts each display result and compares it field by field.
// Depends on bvdf_pkg and the top level of the block.

typedef struct packed {
    bvdf_pkg::charge_level_t level;
    logic [9:0]    shown;
    logic [3:0]    volts;
    logic [3:0]    tenths;
    logic [3:0]    hundredths;
    logic [9:0]    filtered;
    logic          updated;
} display_result_t;

class display_scoreboard;
    logic signed [15:0] fast_thr;
    logic signed [15:0] slow_thr;
    logic [9:0]         large_step;
    logic [9:0]         small_step;
    logic [15:0]        hold_ms;

    logic [bvdf_pkg::AVG_W-1:0] average;
    bit                 seeded;
    logic [9:0]         shown;
    bit                 shown_valid;
    logic [15:0]        since_ms;

    display_result_t    pending_q[$];
    int unsigned        mismatches;

    function new();
        fast_thr    = bvdf_pkg::FAST_THR_RESET;
        slow_thr    = bvdf_pkg::SLOW_THR_RESET;
        large_step  = bvdf_pkg::LARGE_STEP_RESET;
        small_step  = bvdf_pkg::SMALL_STEP_RESET;
        hold_ms     = bvdf_pkg::HOLD_MS_RESET;
        average     = '0;
        seeded      = 0;
        shown       = '0;
        shown_valid = 0;
        since_ms    = '0;
        mismatches  = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] data);
        case (idx)
            bvdf_pkg::CFG_FAST_THR:   fast_thr = data;
            bvdf_pkg::CFG_SLOW_THR:   slow_thr = data;
            bvdf_pkg::CFG_LARGE_STEP: large_step = data[9:0];
            bvdf_pkg::CFG_SMALL_STEP: small_step = data[9:0];
            bvdf_pkg::CFG_HOLD_MS:    hold_ms = data;
            default:                  ;
        endcase
    endfunction

    function void note_sample(logic [15:0] volt, logic signed [15:0] amps, logic [15:0] ms);
        logic [63:0]     acc;
        logic [63:0]     scaled;
        logic [16:0]     since_sum;
        logic [9:0]      filt;
        logic [9:0]      diff;
        bit              upd;
        display_result_t r;

        if (amps > fast_thr)
            r.level = bvdf_pkg::LEVEL_FAST;
        else if (amps > slow_thr)
            r.level = bvdf_pkg::LEVEL_SLOW;
        else
            r.level = bvdf_pkg::LEVEL_NONE;

        if (!seeded) begin
            average = {volt, 12'd0};
            seeded  = 1;
        end
        else begin
            acc = 64'(bvdf_pkg::KEEP_Q16) * 64'(average)
                + 64'(bvdf_pkg::ALPHA_Q16) * 64'({volt, 12'd0})
                + 64'(bvdf_pkg::ROUND_HALF);
            average = acc[43:16];
        end

        scaled = 64'(average) * 64'(bvdf_pkg::SCALE_HUNDRED);
        filt   = (scaled[63:24] > 40'(bvdf_pkg::MAX_SHOWN)) ? bvdf_pkg::MAX_SHOWN
                                                            : scaled[33:24];

        since_sum = {1'b0, since_ms} + {1'b0, ms};
        since_ms  = since_sum[16] ? bvdf_pkg::MAX_MS : since_sum[15:0];

        diff = (filt > shown) ? filt - shown : shown - filt;
        upd  = !shown_valid || (diff > large_step) ||
               ((diff > small_step) && (since_ms > hold_ms));
        if (upd) begin
            shown       = filt;
            shown_valid = 1;
            since_ms    = '0;
        end

        r.shown      = shown;
        r.volts      = 4'(shown / 10'd100);
        r.tenths     = 4'((shown / 10'd10) % 10'd10);
        r.hundredths = 4'(shown % 10'd10);
        r.filtered   = filt;
        r.updated    = upd;
        pending_q.push_back(r);
    endfunction

    function void check_result(display_result_t got);
        display_result_t want;

        if (pending_q.size() == 0) begin
            $error("unexpected result: shown_hundredths %0d, filtered_hundredths %0d",
                   got.shown, got.filtered);
            mismatches++;
            return;
        end
        want = pending_q.pop_front();
        if (got.level != want.level) begin
            $error("charge_level: expected %0d, got %0d", want.level, got.level);
            mismatches++;
        end
        if (got.shown != want.shown) begin
            $error("shown_hundredths: expected %0d, got %0d", want.shown, got.shown);
            mismatches++;
        end
        if (got.volts != want.volts) begin
            $error("digit_volts: expected %0d, got %0d", want.volts, got.volts);
            mismatches++;
        end
        if (got.tenths != want.tenths) begin
            $error("digit_tenths: expected %0d, got %0d", want.tenths, got.tenths);
            mismatches++;
        end
        if (got.hundredths != want.hundredths) begin
            $error("digit_hundredths: expected %0d, got %0d", want.hundredths, got.hundredths);
            mismatches++;
        end
        if (got.filtered != want.filtered) begin
            $error("filtered_hundredths: expected %0d, got %0d", want.filtered, got.filtered);
            mismatches++;
        end
        if (got.updated != want.updated) begin
            $error("shown_updated: expected %0d, got %0d", want.updated, got.updated);
            mismatches++;
        end
    endfunction
endclass

module tb_battery_voltage_display_filter_unit;

    localparam int unsigned RANDOM_SAMPLES = 1100;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned CFG_SLOTS      = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        voltage_sample;
    logic signed [15:0] charge_current;
    logic [15:0]        elapsed_ms;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         charge_level;
    logic [9:0]         shown_hundredths;
    logic [3:0]         digit_volts;
    logic [3:0]         digit_tenths;
    logic [3:0]         digit_hundredths;
    logic [9:0]         filtered_hundredths;
    logic               shown_updated;

    display_scoreboard  sb;
    bit                 calm;
    int unsigned        idle_cycles;

    battery_voltage_display_filter_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .voltage_sample      (voltage_sample),
        .charge_current      (charge_current),
        .elapsed_ms          (elapsed_ms),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .charge_level        (charge_level),
        .shown_hundredths    (shown_hundredths),
        .digit_volts         (digit_volts),
        .digit_tenths        (digit_tenths),
        .digit_hundredths    (digit_hundredths),
        .filtered_hundredths (filtered_hundredths),
        .shown_updated       (shown_updated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(12, 0);
    endfunction

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(5, 0))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(2000, 0)) - 1000);
        endcase
    endfunction

    function automatic logic [15:0] pick_step(int unsigned typical);
        case ($urandom_range(7, 0))
            0:       return 16'(bvdf_pkg::MAX_SHOWN);
            1:       return 16'd1023;
            2:       return 16'($urandom);
            3:       return 16'd0;
            default: return 16'($urandom_range(typical, 0));
        endcase
    endfunction

    // Called at a falling edge; leaves the write enable high for a following write.
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken,
    // with valid still high.
    task automatic send_sample(logic [15:0] volt, logic signed [15:0] amps, logic [15:0] ms);
        int unsigned gap;

        gap = draw_wait();
        repeat (gap) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        voltage_sample <= volt;
        charge_current <= amps;
        elapsed_ms     <= ms;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(volt, amps, ms);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            n = draw_wait();
            repeat (n) begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(display_result_t'{bvdf_pkg::charge_level_t'(charge_level),
                                              shown_hundredths, digit_volts, digit_tenths,
                                              digit_hundredths, filtered_hundredths,
                                              shown_updated});
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned        sent;
        int unsigned        phase_len;
        int unsigned        k;
        int                 base;
        logic [15:0]        volt;
        logic signed [15:0] amps;
        logic [15:0]        ms;

        sb             = new();
        calm           = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        voltage_sample = '0;
        charge_current = '0;
        elapsed_ms     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: the first sample seeds the average and always updates the display.
        send_sample(16'hFFFF, 16'sh8000, 16'd0);
        send_sample(16'h0000, 16'sh7FFF, 16'hFFFF);
        send_sample(16'h0000, 16'sd500, 16'hFFFF);
        send_sample(16'h0000, 16'sd501, 16'd0);
        send_sample(16'h0000, 16'sd50, 16'd1500);
        send_sample(16'h0000, 16'sd51, 16'd1501);
        send_sample(16'h5555, -16'sd1, 16'hAAAA);
        send_sample(16'hAAAA, 16'sd0, 16'h5555);
        wait_drained();

        // Thresholds in reverse order, steps that can never be exceeded and the longest hold.
        write_reg(bvdf_pkg::CFG_FAST_THR, 16'(-100));
        write_reg(bvdf_pkg::CFG_SLOW_THR, 16'd100);
        write_reg(bvdf_pkg::CFG_LARGE_STEP, 16'd1023);
        write_reg(bvdf_pkg::CFG_SMALL_STEP, 16'(bvdf_pkg::MAX_SHOWN));
        write_reg(bvdf_pkg::CFG_HOLD_MS, bvdf_pkg::MAX_MS);
        write_reg(3'(bvdf_pkg::CFG_HOLD_MS + 1), 16'hFFFF);
        cfg_we <= 1'b0;
        send_sample(16'h3000, -16'sd101, 16'hFFFF);
        send_sample(16'h0000, -16'sd100, 16'hFFFF);
        send_sample(16'hFFFF, 16'sd0, 16'hFFFF);
        send_sample(16'h0000, 16'sd100, 16'hFFFF);
        send_sample(16'h4000, 16'sd101, 16'hFFFF);
        wait_drained();

        // Zero steps and zero hold: any change shows at once.
        write_reg(bvdf_pkg::CFG_LARGE_STEP, 16'd0);
        write_reg(bvdf_pkg::CFG_SMALL_STEP, 16'd0);
        write_reg(bvdf_pkg::CFG_HOLD_MS, 16'd0);
        write_reg(bvdf_pkg::CFG_FAST_THR, 16'h7FFF);
        write_reg(bvdf_pkg::CFG_SLOW_THR, 16'h8000);
        cfg_we <= 1'b0;
        send_sample(16'hFFFF, 16'sh7FFF, 16'd0);
        send_sample(16'h0000, 16'sh8000, 16'd0);
        send_sample(16'h0000, 16'sh8001, 16'd1);
        send_sample(16'h8000, 16'sh7FFE, 16'd0);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            calm = ($urandom_range(3, 0) == 0);
            write_reg(bvdf_pkg::CFG_FAST_THR, pick_threshold());
            write_reg(bvdf_pkg::CFG_SLOW_THR, pick_threshold());
            write_reg(bvdf_pkg::CFG_LARGE_STEP, pick_step(30));
            write_reg(bvdf_pkg::CFG_SMALL_STEP, pick_step(8));
            case ($urandom_range(5, 0))
                0:       write_reg(bvdf_pkg::CFG_HOLD_MS, 16'd0);
                1:       write_reg(bvdf_pkg::CFG_HOLD_MS, bvdf_pkg::MAX_MS);
                2:       write_reg(bvdf_pkg::CFG_HOLD_MS, 16'($urandom));
                default: write_reg(bvdf_pkg::CFG_HOLD_MS, 16'($urandom_range(3000, 0)));
            endcase
            write_reg(3'($urandom_range(CFG_SLOTS - 1, bvdf_pkg::CFG_HOLD_MS + 1)),
                      16'($urandom));
            cfg_we <= 1'b0;

            base      = $urandom_range(20480, 8192);
            phase_len = $urandom_range(80, 30);
            for (k = 0; k < phase_len; k++) begin
                case ($urandom_range(19, 0))
                    0, 1: begin
                        volt = 16'($urandom);
                        amps = 16'($urandom);
                        ms   = 16'($urandom);
                    end
                    2: begin
                        base = $urandom_range(20480, 8192);
                        volt = 16'(base);
                        amps = 16'(int'($urandom_range(4000, 0)) - 2000);
                        ms   = 16'($urandom_range(5000, 0));
                    end
                    default: begin
                        volt = 16'(base + int'($urandom_range(64, 0)) - 32);
                        case ($urandom_range(2, 0))
                            0:       amps = 16'(int'(sb.fast_thr)
                                            + int'($urandom_range(4, 0)) - 2);
                            1:       amps = 16'(int'(sb.slow_thr)
                                            + int'($urandom_range(4, 0)) - 2);
                            default: amps = 16'(int'($urandom_range(4000, 0)) - 2000);
                        endcase
                        ms = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(5000, 0))
                                                          : 16'($urandom_range(400, 0));
                    end
                endcase
                send_sample(volt, amps, ms);
                sent++;
                if ((sent == 40) || ($urandom_range(60, 0) == 0))
                    wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: battery_voltage_display_filter_unit.f
+incdir+rtl/core
rtl/core/bvdf_pkg.sv
rtl/core/battery_voltage_display_filter_unit.sv
tb/tb_battery_voltage_display_filter_unit.sv
